/* design/window_threshold_decomposer_assert.svh */
// Assertion macros for the window threshold decomposer.
// Used by the top level only; no other dependencies.
`ifndef WINDOW_THRESHOLD_DECOMPOSER_ASSERT_SVH
`define WINDOW_THRESHOLD_DECOMPOSER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define WTD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define WTD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/wtd_pkg.sv */
// Package for the window threshold decomposer: sizes, beat types,
// controller states and the command/status structs. No dependencies.
`timescale 1ns / 1ps

package wtd_pkg;

  localparam int WINDOW_SIZE  = 9;
  localparam int PATTERN_BITS = 9;
  localparam int POSITIONS    = (WINDOW_SIZE < PATTERN_BITS) ? WINDOW_SIZE : PATTERN_BITS;
  localparam int SAMPLE_W     = 16;
  localparam int TARGET_W     = 8;
  localparam int COUNT_W      = 4;
  localparam int FILL_W       = $clog2(WINDOW_SIZE + 1);
  localparam int SORT_ROUNDS  = POSITIONS;
  localparam int SORT_CNT_W   = (SORT_ROUNDS > 1) ? $clog2(SORT_ROUNDS) : 1;
  localparam int ADDR_W       = 3;
  localparam int DATA_W       = 32;

  localparam logic [SAMPLE_W-1:0] MAX_GREY_RESET     = 16'd255;
  localparam logic [COUNT_W-1:0]  WINDOW_COUNT_RESET = 4'd9;

  // Register index as seen in paddr[2]
  localparam logic REG_MAX_GREY     = 1'b0;
  localparam logic REG_WINDOW_COUNT = 1'b1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last_sample;
    logic [TARGET_W-1:0] target_level;
  } item_t;

  typedef struct packed {
    logic [PATTERN_BITS-1:0] pattern;
    logic [SAMPLE_W-1:0]     count_low;
    logic [SAMPLE_W-1:0]     count_high;
    logic                    last_result;
  } result_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] max_grey;
    logic [COUNT_W-1:0]  window_count;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SORT,
    ST_PREP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic store;
    logic load;
    logic sort_step;
    logic sort_odd;
    logic prep;
    logic emit;
    logic clear;
  } dp_cmd_t;

  typedef struct packed {
    logic emit_end;
  } dp_status_t;

endpackage

/* design/wtd_regs.sv */
// APB-style configuration registers: max_grey and window_count.
// Depends on wtd_pkg.
`timescale 1ns / 1ps

module wtd_regs (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [wtd_pkg::ADDR_W-1:0] paddr,
  input  logic [wtd_pkg::DATA_W-1:0] pwdata,
  output logic [wtd_pkg::DATA_W-1:0] prdata,
  output logic                  pready,
  output wtd_pkg::cfg_t         cfg
);
  import wtd_pkg::*;

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_grey     <= MAX_GREY_RESET;
      cfg.window_count <= WINDOW_COUNT_RESET;
    end else if (wr) begin
      unique case (paddr[2])
        REG_MAX_GREY:     cfg.max_grey     <= pwdata[SAMPLE_W-1:0];
        REG_WINDOW_COUNT: cfg.window_count <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MAX_GREY:     prdata = {{(DATA_W-SAMPLE_W){1'b0}}, cfg.max_grey};
      REG_WINDOW_COUNT: prdata = {{(DATA_W-COUNT_W){1'b0}}, cfg.window_count};
      default:          prdata = '0;
    endcase
  end

endmodule

/* design/wtd_ctrl.sv */
// Controller state machine: load, sort rounds, emission sweep.
// Depends on wtd_pkg; drives the datapath by dp_cmd_t.
`timescale 1ns / 1ps

module wtd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                last_sample,
  input  wtd_pkg::dp_status_t status,
  output wtd_pkg::dp_cmd_t    cmd,
  output logic                busy
);
  import wtd_pkg::*;

  state_t                state, state_next;
  logic [SORT_CNT_W-1:0] sort_cnt, sort_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      sort_cnt <= '0;
    end else begin
      state    <= state_next;
      sort_cnt <= sort_cnt_next;
    end
  end

  always_comb begin
    state_next    = state;
    sort_cnt_next = sort_cnt;
    cmd           = '0;
    busy          = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy      = 1'b0;
        cmd.store = start;
        if (start && last_sample) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load      = 1'b1;
        sort_cnt_next = '0;
        state_next    = ST_SORT;
      end
      ST_SORT: begin
        cmd.sort_step = 1'b1;
        cmd.sort_odd  = sort_cnt[0];
        sort_cnt_next = sort_cnt + 1'b1;
        if (sort_cnt == SORT_CNT_W'(SORT_ROUNDS - 1)) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (status.emit_end) begin
          cmd.clear  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* design/wtd_dp.sv */
// Datapath: window store, sort registers, gap walk and result register.
// Depends on wtd_pkg; commanded by wtd_ctrl.
`timescale 1ns / 1ps

module wtd_dp (
  input  logic                clk,
  input  logic                rst,
  input  wtd_pkg::dp_cmd_t    cmd,
  input  wtd_pkg::item_t      item,
  input  wtd_pkg::cfg_t       cfg,
  output wtd_pkg::dp_status_t status,
  output logic                strobe,
  output wtd_pkg::result_t    result
);
  import wtd_pkg::*;

  logic [SAMPLE_W-1:0] win      [POSITIONS];
  logic [SAMPLE_W-1:0] srt      [POSITIONS];
  logic [SAMPLE_W-1:0] srt_next [POSITIONS];
  logic [FILL_W-1:0]   fill;
  logic [TARGET_W-1:0] held_target;
  logic [SAMPLE_W-1:0] lo;
  logic [SAMPLE_W-1:0] smax, smax_next;
  logic                top_pos;
  logic [COUNT_W-1:0]  idx;
  logic [COUNT_W-1:0]  used;
  logic [SAMPLE_W-1:0] hi, tgt;
  logic                gap_pos, top_gap;
  result_t             res_next;

  assign used = (cfg.window_count > COUNT_W'(POSITIONS)) ? COUNT_W'(POSITIONS)
                                                        : cfg.window_count;
  assign tgt  = {{(SAMPLE_W-TARGET_W){1'b0}}, held_target};

  // One transposition round: pairs of one parity compare and swap.
  always_comb begin
    for (int k = 0; k < POSITIONS; k++) begin
      srt_next[k] = srt[k];
    end
    for (int k = 0; k < POSITIONS - 1; k++) begin
      if ((((k % 2) == 1) == cmd.sort_odd) && (srt[k] > srt[k+1])) begin
        srt_next[k]   = srt[k+1];
        srt_next[k+1] = srt[k];
      end
    end
  end

  always_comb begin
    smax_next = '0;
    for (int k = 0; k < POSITIONS; k++) begin
      if (used == COUNT_W'(k + 1)) begin
        smax_next = srt[k];
      end
    end
  end

  assign status.emit_end = (idx == used);
  assign top_gap         = (idx == used);
  assign hi              = top_gap ? cfg.max_grey : srt[0];
  assign gap_pos         = (hi > lo);

  always_comb begin
    res_next = '0;
    for (int k = 0; k < POSITIONS; k++) begin
      res_next.pattern[k] = (COUNT_W'(k) < used) && (win[k] >= hi);
    end
    priority if (tgt >= hi) begin
      res_next.count_low  = '0;
      res_next.count_high = hi - lo;
    end else if (tgt <= lo) begin
      res_next.count_low  = hi - lo;
      res_next.count_high = '0;
    end else begin
      res_next.count_high = tgt - lo;
      res_next.count_low  = hi - tgt;
    end
    res_next.last_result = top_gap || (!top_pos && (hi == smax));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill        <= '0;
      held_target <= '0;
      strobe      <= 1'b0;
    end else begin
      strobe <= cmd.emit && gap_pos;
      if (cmd.store) begin
        if (fill < FILL_W'(WINDOW_SIZE)) begin
          fill <= fill + 1'b1;
        end
        if (item.last_sample) begin
          held_target <= item.target_level;
        end
      end
      if (cmd.clear) begin
        fill <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < POSITIONS; k++) begin
      if (cmd.clear) begin
        win[k] <= '0;
      end else if (cmd.store && (fill == FILL_W'(k))) begin
        win[k] <= item.sample;
      end
    end
    if (cmd.load) begin
      for (int k = 0; k < POSITIONS; k++) begin
        srt[k] <= (COUNT_W'(k) < used) ? win[k] : '1;
      end
    end else if (cmd.sort_step) begin
      srt <= srt_next;
    end else if (cmd.emit) begin
      for (int k = 0; k < POSITIONS - 1; k++) begin
        srt[k] <= srt[k+1];
      end
    end
    if (cmd.prep) begin
      smax    <= smax_next;
      top_pos <= cfg.max_grey > smax_next;
      lo      <= '0;
      idx     <= '0;
    end else if (cmd.emit) begin
      lo  <= hi;
      idx <= idx + 1'b1;
    end
    if (cmd.emit) begin
      result <= res_next;
    end
  end

endmodule

/* design/window_threshold_decomposer.sv */
// Top level of the window threshold decomposer.
// Depends on wtd_pkg, wtd_regs, wtd_ctrl, wtd_dp and the assertion header.
//
//   channel   signals                              handshake
//   -------   ----------------------------------   ------------------------------
//   input     item (sample, last_sample, target)   start && !busy
//   result    result (pattern, counts, last)       strobe, one cycle, no stall
//   config    psel penable pwrite paddr pwdata     APB write, pready tied high
//
// A sample beat without the last mark is stored while the block stays idle.
// The closing beat keeps the block busy through a load step, the nine
// odd-even transposition rounds of the sort network, a preparation step
// and the emission walk over n + 1 gaps (n = positions in use). Each
// result shows in the cycle after its gap is walked; a beat for the top
// gap overlaps the first idle cycle, while an empty top gap leaves the
// final beat inside the busy window. Reset is synchronous and clears the
// controller, fill index, held target and the strobe. The receiver cannot
// stall, so results are never held back.
`timescale 1ns / 1ps

module window_threshold_decomposer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  wtd_pkg::item_t              item,
  output logic                        strobe,
  output wtd_pkg::result_t            result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wtd_pkg::ADDR_W-1:0]  paddr,
  input  logic [wtd_pkg::DATA_W-1:0]  pwdata,
  output logic [wtd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import wtd_pkg::*;

  `include "window_threshold_decomposer_assert.svh"

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  // Configuration: the user must write it only while idle, which the block leaves unchecked; read live by the datapath.
  wtd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequence the window: hold in idle while samples stream in, then load,
  // sort, prepare and walk the gaps.
  wtd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .last_sample (item.last_sample),
    .status      (status),
    .cmd         (cmd),
    .busy        (busy)
  );

  // Store, sort and emit; the result register drives the output beat.
  wtd_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .item   (item),
    .cfg    (cfg),
    .status (status),
    .strobe (strobe),
    .result (result)
  );

  // An idle cycle walks no gap, so no result may follow it.
  `WTD_ASSERT_NEXT(a_idle_no_result, clk, rst, !busy, !strobe,
                   "result beat after an idle cycle")
  // A beat seen while idle comes from the top gap and closes the window.
  `WTD_ASSERT_NOW(a_idle_beat_last, clk, rst, strobe && !busy, result.last_result,
                  "idle result beat without the last mark")
  // Work starts only from a closing beat.
  `WTD_ASSERT_NOW(a_busy_from_last, clk, rst, $rose(busy),
                  $past(start && item.last_sample),
                  "busy without a closing beat")

endmodule
